// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

// File: sv/gmbd_pkg.sv
`timescale 1ns / 1ps
// types, constants and arithmetic helpers of the gell-mann decomposer
// no dependencies
package gmbd_pkg;

	localparam int STORE_DEPTH = 63;
	localparam int ADDR_W      = 6;
	localparam int DIM_W       = 4;
	localparam int WORD_W      = 64;

	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

	localparam logic signed [35:0] SAT_MAX = 36'sh007FFFFFFF;
	localparam logic signed [35:0] SAT_MIN = -36'sh0080000000;

	typedef enum logic {
		OP_ENTRY   = 1'b0,
		OP_ROW_END = 1'b1
	} gmbd_op_t;

	typedef struct packed {
		gmbd_op_t           opcode;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic signed [23:0] entry_re;
		logic signed [23:0] entry_im;
	} gmbd_in_t;

	typedef struct packed {
		logic [5:0]         coef_index;
		logic signed [31:0] coef_re;
		logic signed [31:0] coef_im;
		logic               empty_res;
		logic               last;
	} gmbd_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KV,
		ST_SUB,
		ST_MUL,
		ST_RND,
		ST_UPD_A,
		ST_UPD_B,
		ST_SCAN,
		ST_FLUSH,
		ST_FINAL
	} gmbd_state_t;

	// 1/sqrt(k(k+1)) in unsigned q16
	function automatic logic [15:0] level_q16(input logic [2:0] k);
		logic [15:0] c;
		case (k)
			3'd1: c = 16'd46341;
			3'd2: c = 16'd26755;
			3'd3: c = 16'd18919;
			3'd4: c = 16'd14654;
			3'd5: c = 16'd11965;
			3'd6: c = 16'd10112;
			3'd7: c = 16'd8758;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

	// drop 16 fraction bits, round to nearest, ties away from zero
	function automatic logic signed [34:0] round_q16(input logic signed [50:0] p);
		logic [50:0] mag;
		logic [50:0] sum;
		logic [34:0] r;
		mag = p[50] ? 51'(-p) : 51'(p);
		sum = mag + 51'd32768;
		r   = sum[50:16];
		return p[50] ? $signed(-r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
		logic signed [31:0] y;
		if (x > SAT_MAX) begin
			y = 32'sh7FFFFFFF;
		end else if (x < SAT_MIN) begin
			y = -32'sh7FFFFFFF - 32'sd1;
		end else begin
			y = x[31:0];
		end
		return y;
	endfunction

endpackage

// File: sv/gell_mann_basis_decompose.sv
`timescale 1ns / 1ps
// channel     | signals                     | transfer when
// ------------+-----------------------------+------------------------------
// command in  | start, busy, item           | start high and busy low
// result out  | res_strobe, res             | every cycle res_strobe is high
// config      | cfg_we, cfg_wdata           | cfg_we high
//
// off-diagonal entry: multiply, round, read-modify-write of two words in the
//   coefficient ram through its single write port
// diagonal entry for k > 0: k*v, subtract, multiply, round, write; row zero
//   only k*v and subtract; row end with level term: the same steps as k > 0
// final row end adds a scan of the 63-entry store; each nonzero result is held
//   until the next is found or the scan ends, then leaves on res_strobe and cannot be stalled
// reset clears the store through per-entry valid bits, no clearing pass
// depends on gmbd_pkg, gmbd_ram
module gell_mann_basis_decompose #(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gmbd_pkg::gmbd_in_t item,
	output logic              res_strobe,
	output gmbd_pkg::gmbd_out_t res,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);

	import gmbd_pkg::*;

	localparam logic [DIM_W-1:0] MAX_N = DIM_W'(MAX_DIM);

	gmbd_state_t state_q, state_d;

	logic [DIM_W-1:0] dim_q, n_eff;
	logic row_diag_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic signed [31:0] diag_re_q, diag_im_q;

	// per-item registers
	logic signed [23:0] vre_q, vim_q;
	logic [2:0] k_q;
	logic [ADDR_W-1:0] addr_q;
	logic upper_q, level_q, scan_after_q;

	// datapath pipeline
	logic signed [27:0] kv_re_s1, kv_im_s1;
	logic signed [33:0] diff_re_q, diff_im_q;
	logic signed [50:0] prod_re_s2, prod_im_s2;
	logic signed [34:0] rnd_re_q, rnd_im_q;

	// scan
	logic [ADDR_W-1:0] scan_cnt_q, scan_idx_s1;
	logic scan_s1, rd_valid_s1;
	logic pend_vld_q;
	logic [ADDR_W-1:0] pend_idx_q;
	logic signed [31:0] pend_re_q, pend_im_q;
	logic res_strobe_q;
	gmbd_out_t res_q;

	// ram
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	// accept decode
	logic accept, is_entry, r_in, c_in, is_diag, acc_off, acc_diag, acc_end, last_row, need_lvl;
	logic [2:0] lo_idx, hi_idx;
	logic [7:0] pair_full, lvl_full;

	// arithmetic
	logic signed [3:0] k_s;
	logic signed [33:0] mul_x_re, mul_x_im;
	logic signed [16:0] mul_c;
	logic signed [31:0] old_re, old_im;
	logic signed [35:0] base_re, base_im, add_re, add_im, upd_re, upd_im;
	logic signed [35:0] rnd_re36, rnd_im36, dsum_re, dsum_im;
	logic scan_nz;

	gmbd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (dim_q < DIM_W'(2)) begin
			n_eff = DIM_W'(2);
		end else if (dim_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = dim_q;
		end
	end

	assign accept   = start && (state_q == ST_IDLE);
	assign is_entry = (item.opcode == OP_ENTRY);
	assign r_in     = {1'b0, item.row_index} < n_eff;
	assign c_in     = {1'b0, item.col_index} < n_eff;
	assign is_diag  = (item.row_index == item.col_index);
	assign acc_off  = accept && is_entry && r_in && c_in && !is_diag;
	assign acc_diag = accept && is_entry && r_in && c_in && is_diag;
	assign acc_end  = accept && !is_entry && r_in;
	assign last_row = ({1'b0, item.row_index} == n_eff - DIM_W'(1));
	assign need_lvl = !row_diag_q && (item.row_index != 3'd0);

	assign lo_idx = (item.row_index < item.col_index) ? item.row_index : item.col_index;
	assign hi_idx = (item.row_index < item.col_index) ? item.col_index : item.row_index;
	// pair slot (2n-1-a)*a + 2*(b-a-1)
	assign pair_full = (8'({n_eff, 1'b0}) - 8'd1 - 8'(lo_idx)) * 8'(lo_idx)
		+ 8'({hi_idx - lo_idx - 3'd1, 1'b0});
	// level slot n(n-1) + k - 1
	assign lvl_full = 8'(n_eff) * (8'(n_eff) - 8'd1) + 8'(item.row_index) - 8'd1;

	assign k_s      = $signed({1'b0, k_q});
	assign mul_x_re = level_q ? diff_re_q : {{10{vre_q[23]}}, vre_q};
	assign mul_x_im = level_q ? diff_im_q : {{10{vim_q[23]}}, vim_q};
	assign mul_c    = $signed({1'b0, level_q ? level_q16(k_q) : INV_SQRT2_Q16});

	assign old_re   = rd_valid_s1 ? $signed(ram_rdata[63:32]) : 32'sd0;
	assign old_im   = rd_valid_s1 ? $signed(ram_rdata[31:0]) : 32'sd0;
	assign rnd_re36 = {rnd_re_q[34], rnd_re_q};
	assign rnd_im36 = {rnd_im_q[34], rnd_im_q};
	assign dsum_re  = diag_re_q + vre_q;
	assign dsum_im  = diag_im_q + vim_q;
	assign scan_nz  = scan_s1 && ((old_re != 32'sd0) || (old_im != 32'sd0));

	always_comb begin
		// level writes replace the slot, pair updates accumulate
		base_re = level_q ? 36'sd0 : {{4{old_re[31]}}, old_re};
		base_im = level_q ? 36'sd0 : {{4{old_im[31]}}, old_im};
		if (state_q == ST_UPD_B) begin
			add_re = upper_q ? -rnd_im36 : rnd_im36;
			add_im = upper_q ? rnd_re36 : -rnd_re36;
		end else begin
			add_re = rnd_re36;
			add_im = rnd_im36;
		end
		upd_re = base_re + add_re;
		upd_im = base_im + add_im;
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_raddr = addr_q;
		ram_wdata = {sat32(upd_re), sat32(upd_im)};
		case (state_q)
			ST_IDLE: begin
				if (acc_off) begin
					state_d = ST_MUL;
				end else if (acc_diag || (acc_end && need_lvl)) begin
					state_d = ST_KV;
				end else if (acc_end && last_row) begin
					state_d = ST_SCAN;
				end
			end
			ST_KV: state_d = ST_SUB;
			ST_SUB: state_d = level_q ? ST_MUL : ST_IDLE;
			ST_MUL: state_d = ST_RND;
			ST_RND: state_d = ST_UPD_A;
			ST_UPD_A: begin
				ram_we = 1'b1;
				if (level_q) begin
					state_d = scan_after_q ? ST_SCAN : ST_IDLE;
				end else begin
					ram_raddr = addr_q + ADDR_W'(1);
					state_d   = ST_UPD_B;
				end
			end
			ST_UPD_B: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q + ADDR_W'(1);
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				ram_raddr = scan_cnt_q;
				if (scan_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_FINAL;
			ST_FINAL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dim_q        <= DIM_W'(2);
			row_diag_q   <= 1'b0;
			valid_q      <= '0;
			diag_re_q    <= '0;
			diag_im_q    <= '0;
			scan_cnt_q   <= '0;
			scan_s1      <= 1'b0;
			pend_vld_q   <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= (scan_nz && pend_vld_q) || (state_q == ST_FINAL);
			scan_s1      <= (state_q == ST_SCAN);
			if (cfg_we) begin
				dim_q <= cfg_wdata;
			end
			if (acc_diag) begin
				row_diag_q <= 1'b1;
			end else if (acc_end) begin
				row_diag_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_SUB) begin
				diag_re_q <= sat32(dsum_re);
				diag_im_q <= sat32(dsum_im);
			end
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + ADDR_W'(1);
			end
			if (scan_nz) begin
				pend_vld_q <= 1'b1;
			end
			if (state_q == ST_FINAL) begin
				pend_vld_q   <= 1'b0;
				scan_cnt_q   <= '0;
				valid_q      <= '0;
				diag_re_q    <= '0;
				diag_im_q    <= '0;
				row_diag_q   <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_valid_s1 <= valid_q[ram_raddr];
		scan_idx_s1 <= scan_cnt_q;
		if (accept) begin
			vre_q        <= is_entry ? item.entry_re : 24'sd0;
			vim_q        <= is_entry ? item.entry_im : 24'sd0;
			k_q          <= item.row_index;
			upper_q      <= item.row_index < item.col_index;
			addr_q       <= acc_off ? pair_full[ADDR_W-1:0] : lvl_full[ADDR_W-1:0];
			level_q      <= (acc_diag && (item.row_index != 3'd0)) || acc_end;
			scan_after_q <= acc_end && last_row;
		end
		if (state_q == ST_KV) begin
			kv_re_s1 <= k_s * vre_q;
			kv_im_s1 <= k_s * vim_q;
		end
		if (state_q == ST_SUB) begin
			diff_re_q <= diag_re_q - kv_re_s1;
			diff_im_q <= diag_im_q - kv_im_s1;
		end
		if (state_q == ST_MUL) begin
			prod_re_s2 <= mul_x_re * mul_c;
			prod_im_s2 <= mul_x_im * mul_c;
		end
		if (state_q == ST_RND) begin
			rnd_re_q <= round_q16(prod_re_s2);
			rnd_im_q <= round_q16(prod_im_s2);
		end
		if (scan_nz) begin
			// a newer nonzero slot releases the held one as a non-final result
			res_q.coef_index <= pend_idx_q;
			res_q.coef_re    <= pend_re_q;
			res_q.coef_im    <= pend_im_q;
			res_q.empty_res  <= 1'b0;
			res_q.last       <= 1'b0;
			pend_idx_q       <= scan_idx_s1;
			pend_re_q        <= old_re;
			pend_im_q        <= old_im;
		end
		if (state_q == ST_FINAL) begin
			res_q.coef_index <= pend_vld_q ? pend_idx_q : '0;
			res_q.coef_re    <= pend_vld_q ? pend_re_q : 32'sd0;
			res_q.coef_im    <= pend_vld_q ? pend_im_q : 32'sd0;
			res_q.empty_res  <= !pend_vld_q;
			res_q.last       <= 1'b1;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign res_strobe = res_strobe_q;
	assign res        = res_q;

endmodule

// File: sv/gmbd_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module gmbd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/gmbd_checker.sv
`timescale 1ns / 1ps
// port-level checks on the decomposer result stream, bound to the top level
// depends on gmbd_pkg, assert_macros.svh
`include "assert_macros.svh"

module gmbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                res_strobe,
	input gmbd_pkg::gmbd_out_t res
);

	import gmbd_pkg::*;

	`ASSERT_IMPLY(a_empty_is_last, clk, arst_n, res_strobe && res.empty_res, res.last)
	`ASSERT_IMPLY(a_empty_zero, clk, arst_n, res_strobe && res.empty_res, (res.coef_index == '0) && (res.coef_re == '0) && (res.coef_im == '0))
	`ASSERT_NEXT(a_gap_after_last, clk, arst_n, res_strobe && res.last, !res_strobe)
	`ASSERT_IMPLY(a_busy_mid_stream, clk, arst_n, res_strobe && !res.last, busy)
	`ASSERT_IMPLY(a_index_ascends, clk, arst_n, res_strobe && $past(res_strobe) && !$past(res.last), res.coef_index > $past(res.coef_index))

endmodule

bind gell_mann_basis_decompose gmbd_checker u_gmbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.res_strobe(res_strobe),
	.res       (res)
);
